// ===== src/rv32x_pkg.sv =====
// Shared constants, types and helpers for the RV32I execute unit.
`default_nettype none
package rv32x_pkg;

	localparam int MEM_ADDR_BITS_DEF = 16;

	// Operation codes
	localparam logic [5:0] OP_ADD    = 6'd0;
	localparam logic [5:0] OP_SUB    = 6'd1;
	localparam logic [5:0] OP_AND    = 6'd2;
	localparam logic [5:0] OP_OR     = 6'd3;
	localparam logic [5:0] OP_XOR    = 6'd4;
	localparam logic [5:0] OP_SLL    = 6'd5;
	localparam logic [5:0] OP_SRL    = 6'd6;
	localparam logic [5:0] OP_SRA    = 6'd7;
	localparam logic [5:0] OP_SLT    = 6'd8;
	localparam logic [5:0] OP_SLTU   = 6'd9;
	localparam logic [5:0] OP_SLLI   = 6'd10;
	localparam logic [5:0] OP_SRLI   = 6'd11;
	localparam logic [5:0] OP_SRAI   = 6'd12;
	localparam logic [5:0] OP_ADDI   = 6'd13;
	localparam logic [5:0] OP_ANDI   = 6'd14;
	localparam logic [5:0] OP_ORI    = 6'd15;
	localparam logic [5:0] OP_XORI   = 6'd16;
	localparam logic [5:0] OP_SLTI   = 6'd17;
	localparam logic [5:0] OP_SLTIU  = 6'd18;
	localparam logic [5:0] OP_LB     = 6'd19;
	localparam logic [5:0] OP_LBU    = 6'd20;
	localparam logic [5:0] OP_LH     = 6'd21;
	localparam logic [5:0] OP_LHU    = 6'd22;
	localparam logic [5:0] OP_LW     = 6'd23;
	localparam logic [5:0] OP_JALR   = 6'd24;
	localparam logic [5:0] OP_EBREAK = 6'd25;
	localparam logic [5:0] OP_ECALL  = 6'd26;
	localparam logic [5:0] OP_SB     = 6'd27;
	localparam logic [5:0] OP_SH     = 6'd28;
	localparam logic [5:0] OP_SW     = 6'd29;
	localparam logic [5:0] OP_BEQ    = 6'd30;
	localparam logic [5:0] OP_BGE    = 6'd31;
	localparam logic [5:0] OP_BGEU   = 6'd32;
	localparam logic [5:0] OP_BLT    = 6'd33;
	localparam logic [5:0] OP_BLTU   = 6'd34;
	localparam logic [5:0] OP_BNE    = 6'd35;
	localparam logic [5:0] OP_JAL    = 6'd36;
	localparam logic [5:0] OP_AUIPC  = 6'd37;
	localparam logic [5:0] OP_LUI    = 6'd38;

	// Exit instruction: addi a0, x0, 255
	localparam logic [4:0]  EXIT_REG = 5'd10;
	localparam logic [31:0] EXIT_IMM = 32'h0000_00FF;

	// Access size in bytes
	localparam logic [2:0] SZ_BYTE = 3'd1;
	localparam logic [2:0] SZ_HALF = 3'd2;
	localparam logic [2:0] SZ_WORD = 3'd4;

	// Execute results for one instruction
	typedef struct packed {
		logic        bad;
		logic        is_exit;
		logic        wr;
		logic [31:0] val;
		logic [31:0] npc;
		logic        is_load;
		logic        is_store;
		logic [2:0]  size;
		logic [31:0] addr;
	} exec_res_t;

	// Shape loaded bytes into the register value
	function automatic logic [31:0] load_fmt(input logic [5:0] op, input logic [31:0] w);
		logic [31:0] r;
		begin
			case (op)
				OP_LB:   r = {{24{w[7]}}, w[7:0]};
				OP_LBU:  r = {24'd0, w[7:0]};
				OP_LH:   r = {{16{w[15]}}, w[15:0]};
				OP_LHU:  r = {16'd0, w[15:0]};
				default: r = w;
			endcase
			return r;
		end
	endfunction

endpackage
`default_nettype wire

// ===== src/rv32x_regfile.sv =====
// Register file: 32x32 synchronous memory with two read ports and reset valid bits.
`default_nettype none
module rv32x_regfile
	import rv32x_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        re,
	input  wire logic [4:0]  raddr_a,
	input  wire logic [4:0]  raddr_b,
	input  wire logic        we,
	input  wire logic [4:0]  waddr,
	input  wire logic [31:0] wdata,
	output logic [31:0]      rdata_a,
	output logic [31:0]      rdata_b
);

	logic [31:0] mem [32];
	logic [31:0] vld_q;
	logic [31:0] rd_a_q, rd_b_q, byp_val_q;
	logic        vld_a_q, vld_b_q, byp_a_q, byp_b_q;

	// storage and read data
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) begin
			rd_a_q <= mem[raddr_a];
			rd_b_q <= mem[raddr_b];
			byp_val_q <= wdata;
		end
	end

	// valid bits and bypass flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
			byp_a_q <= 1'b0;
			byp_b_q <= 1'b0;
		end else begin
			if (we) vld_q[waddr] <= 1'b1;
			if (re) begin
				vld_a_q <= vld_q[raddr_a];
				vld_b_q <= vld_q[raddr_b];
				byp_a_q <= we && (waddr == raddr_a);
				byp_b_q <= we && (waddr == raddr_b);
			end
		end
	end

	assign rdata_a = byp_a_q ? byp_val_q : (vld_a_q ? rd_a_q : 32'd0);
	assign rdata_b = byp_b_q ? byp_val_q : (vld_b_q ? rd_b_q : 32'd0);

endmodule
`default_nettype wire

// ===== src/rv32x_dmem.sv =====
// Data memory: four byte lanes, misaligned wrapping access, clearing pass after reset.
`default_nettype none
module rv32x_dmem
	import rv32x_pkg::*;
#(
	parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     re,
	input  wire logic                     we,
	input  wire logic [MEM_ADDR_BITS-1:0] addr,
	input  wire logic [2:0]               size,
	input  wire logic [31:0]              wdata,
	output logic [31:0]                   rdata,
	output logic                          busy
);

	localparam int LANE_BITS = MEM_ADDR_BITS - 2;
	localparam int DEPTH     = 1 << LANE_BITS;

	logic                 clr_q;
	logic [LANE_BITS-1:0] clr_idx_q;
	logic [1:0]           lo_q;
	logic [7:0]           lane_rd [4];

	// clearing sweep, one row of four lanes a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + LANE_BITS'(1);
			if (&clr_idx_q) clr_q <= 1'b0;
		end
	end
	assign busy = clr_q;

	always_ff @(posedge clk) begin
		if (re) lo_q <= addr[1:0];
	end

	// per-lane storage
	for (genvar g = 0; g < 4; g++) begin : g_lane
		logic [7:0]               mem [DEPTH];
		logic [1:0]               k;
		logic [MEM_ADDR_BITS-1:0] full;
		logic [LANE_BITS-1:0]     la;
		logic                     lwe;

		assign k    = 2'(g) - addr[1:0];
		assign full = addr + MEM_ADDR_BITS'(k);
		assign la   = full[MEM_ADDR_BITS-1:2];
		assign lwe  = we && ({1'b0, k} < size);

		always_ff @(posedge clk) begin
			if (clr_q) mem[clr_idx_q] <= 8'd0;
			else if (lwe) mem[la] <= wdata[8*k +: 8];
			if (re) lane_rd[g] <= mem[la];
		end
	end

	// rotate lanes back to byte order
	always_comb begin
		for (int i = 0; i < 4; i++) rdata[8*i +: 8] = lane_rd[2'(lo_q + 2'(i))];
	end

endmodule
`default_nettype wire

// ===== src/rv32x_exec.sv =====
// Execute logic: ALU, branch decision, next pc and memory request of one instruction.
`default_nettype none
module rv32x_exec
	import rv32x_pkg::*;
(
	input  wire logic [5:0]  func,
	input  wire logic [4:0]  dest_index,
	input  wire logic [4:0]  src1_index,
	input  wire logic [31:0] imm,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	input  wire logic [31:0] pc,
	output exec_res_t        res
);

	logic [31:0] addr, pc4, pcimm;
	logic        take, slt_ab, sltu_ab;

	assign addr    = a + imm;
	assign pc4     = pc + 32'd4;
	assign pcimm   = pc + imm;
	assign slt_ab  = $signed(a) < $signed(b);
	assign sltu_ab = a < b;

	always_comb begin
		res          = '0;
		res.bad      = func > OP_LUI;
		res.is_exit  = (func == OP_ADDI) && (dest_index == EXIT_REG)
		               && (src1_index == 5'd0) && (imm == EXIT_IMM);
		res.addr     = addr;
		res.npc      = pc4;
		res.size     = SZ_BYTE;
		take         = 1'b0;
		res.wr       = 1'b1;
		case (func)
			OP_ADD:   res.val = a + b;
			OP_SUB:   res.val = a - b;
			OP_AND:   res.val = a & b;
			OP_OR:    res.val = a | b;
			OP_XOR:   res.val = a ^ b;
			OP_SLL:   res.val = a << b[4:0];
			OP_SRL:   res.val = a >> b[4:0];
			OP_SRA:   res.val = 32'($signed(a) >>> b[4:0]);
			OP_SLT:   res.val = {31'd0, slt_ab};
			OP_SLTU:  res.val = {31'd0, sltu_ab};
			OP_SLLI:  res.val = a << imm[4:0];
			OP_SRLI:  res.val = a >> imm[4:0];
			OP_SRAI:  res.val = 32'($signed(a) >>> imm[4:0]);
			OP_ADDI:  res.val = addr;
			OP_ANDI:  res.val = a & imm;
			OP_ORI:   res.val = a | imm;
			OP_XORI:  res.val = a ^ imm;
			OP_SLTI:  res.val = {31'd0, $signed(a) < $signed(imm)};
			OP_SLTIU: res.val = {31'd0, a < imm};
			OP_LB, OP_LBU: res.is_load = 1'b1;
			OP_LH, OP_LHU: begin
				res.is_load = 1'b1;
				res.size    = SZ_HALF;
			end
			OP_LW: begin
				res.is_load = 1'b1;
				res.size    = SZ_WORD;
			end
			OP_JALR: begin
				res.val = pc4;
				res.npc = {addr[31:1], 1'b0};
			end
			OP_EBREAK, OP_ECALL: res.wr = 1'b0;
			OP_SB: begin
				res.wr = 1'b0;
				res.is_store = 1'b1;
			end
			OP_SH: begin
				res.wr = 1'b0;
				res.is_store = 1'b1;
				res.size = SZ_HALF;
			end
			OP_SW: begin
				res.wr = 1'b0;
				res.is_store = 1'b1;
				res.size = SZ_WORD;
			end
			OP_BEQ:  begin res.wr = 1'b0; take = (a == b); end
			OP_BGE:  begin res.wr = 1'b0; take = !slt_ab; end
			OP_BGEU: begin res.wr = 1'b0; take = !sltu_ab; end
			OP_BLT:  begin res.wr = 1'b0; take = slt_ab; end
			OP_BLTU: begin res.wr = 1'b0; take = sltu_ab; end
			OP_BNE:  begin res.wr = 1'b0; take = (a != b); end
			OP_JAL: begin
				res.val = pc4;
				res.npc = pcimm;
			end
			OP_AUIPC: res.val = pcimm;
			default:  res.val = imm;
		endcase
		if (take) res.npc = pcimm;
	end

endmodule
`default_nettype wire

// ===== src/rv32i_execute_unit.sv =====
// RV32I execute unit top level: input stage, execute stage, write-back and output register.
// Usage: one decoded instruction enters per input beat (in_valid/in_stall); each yields
// exactly one result beat (out_valid/out_stall) with register write, next pc, halt and status.
// Flow: an instruction is not accepted while another is in the input stage. The accept
// edge reads the register file, the input stage executes and issues the data memory access,
// the following stage shapes load data, and the write-back edge of one instruction is the
// accept edge of the next (register read bypassed from that write).
// A result waits in the output register while the next instruction runs; once both the
// output register and the execute stage are full, in_stall rises until out_stall drops.
// Reset: registers, pc and halt clear at once; the data memory is then swept to zero at
// four bytes a cycle over its 2^(MEM_ADDR_BITS-2) rows (16384 by default), with in_stall high.
// After the exit instruction (addi a0,x0,255) every item leaves state unchanged and
// reports halted with the exit byte.
`default_nettype none
module rv32i_execute_unit
	import rv32x_pkg::*;
#(
	parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [5:0]  func,
	input  wire logic [4:0]  dest_index,
	input  wire logic [4:0]  src1_index,
	input  wire logic [4:0]  src2_index,
	input  wire logic [31:0] immediate,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             reg_written,
	output logic [4:0]       written_index,
	output logic [31:0]      written_value,
	output logic [31:0]      next_pc,
	output logic             halted,
	output logic [7:0]       exit_byte,
	output logic             status
);

	logic        accept, s2_go, mem_busy, active;
	logic        s1_v_s1, s2_v_s2;
	logic [5:0]  func_s1;
	logic [4:0]  rd_s1, r1_s1;
	logic [31:0] imm_s1;
	logic [31:0] a, b, ld_word, wb_val;
	exec_res_t   res;

	logic        wr_s2, load_s2, halt_s2, bad_s2;
	logic [5:0]  func_s2;
	logic [4:0]  rd_s2;
	logic [31:0] val_s2, npc_s2;
	logic [7:0]  exit_s2;

	logic [31:0] pc_q;
	logic        halt_q;
	logic [7:0]  x10_q;

	// handshake
	assign s2_go    = s2_v_s2 && (!out_valid || !out_stall);
	assign in_stall = mem_busy || s1_v_s1 || (s2_v_s2 && !s2_go);
	assign accept   = in_valid && !in_stall;

	rv32x_regfile u_rf (
		.clk     (clk),
		.arst_n  (arst_n),
		.re      (accept),
		.raddr_a (src1_index),
		.raddr_b (src2_index),
		.we      (s2_go && wr_s2),
		.waddr   (rd_s2),
		.wdata   (wb_val),
		.rdata_a (a),
		.rdata_b (b)
	);

	rv32x_exec u_exec (
		.func       (func_s1),
		.dest_index (rd_s1),
		.src1_index (r1_s1),
		.imm        (imm_s1),
		.a          (a),
		.b          (b),
		.pc         (pc_q),
		.res        (res)
	);

	assign active = s1_v_s1 && !halt_q && !res.bad && !res.is_exit;

	rv32x_dmem #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (s1_v_s1),
		.we     (active && res.is_store),
		.addr   (res.addr[MEM_ADDR_BITS-1:0]),
		.size   (res.size),
		.wdata  (b),
		.rdata  (ld_word),
		.busy   (mem_busy)
	);

	assign wb_val = load_s2 ? load_fmt(func_s2, ld_word) : val_s2;

	// stage valids and architectural control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_s1   <= 1'b0;
			s2_v_s2   <= 1'b0;
			out_valid <= 1'b0;
			pc_q      <= '0;
			halt_q    <= 1'b0;
			x10_q     <= '0;
		end else begin
			s1_v_s1 <= accept;
			s2_v_s2 <= s1_v_s1 || (s2_v_s2 && !s2_go);
			if (s2_go) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			if (active) pc_q <= res.npc;
			if (s1_v_s1 && !halt_q && !res.bad && res.is_exit) halt_q <= 1'b1;
			if (s2_go && wr_s2 && rd_s2 == EXIT_REG) x10_q <= wb_val[7:0];
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			rd_s1   <= dest_index;
			r1_s1   <= src1_index;
			imm_s1  <= immediate;
		end
	end

	// execute stage payload
	always_ff @(posedge clk) begin
		if (s1_v_s1) begin
			wr_s2   <= active && res.wr && (rd_s1 != 5'd0);
			load_s2 <= active && res.is_load;
			func_s2 <= func_s1;
			rd_s2   <= rd_s1;
			val_s2  <= res.val;
			npc_s2  <= active ? res.npc : pc_q;
			halt_s2 <= halt_q || (!res.bad && res.is_exit);
			exit_s2 <= (halt_q || (!res.bad && res.is_exit)) ? x10_q : 8'd0;
			bad_s2  <= res.bad;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (s2_go) begin
			reg_written   <= wr_s2;
			written_index <= wr_s2 ? rd_s2 : 5'd0;
			written_value <= wr_s2 ? wb_val : 32'd0;
			next_pc       <= npc_s2;
			halted        <= halt_s2;
			exit_byte     <= exit_s2;
			status        <= bad_s2;
		end
	end

endmodule
`default_nettype wire

// ===== tb/rv32x_exec_checker.sv =====
// Beat monitor, instruction predictor and result comparator for the RV32I execute unit.
`default_nettype none
module rv32x_exec_checker
	import rv32x_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [5:0]  func,
	input  wire logic [4:0]  dest_index,
	input  wire logic [4:0]  src1_index,
	input  wire logic [4:0]  src2_index,
	input  wire logic [31:0] immediate,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic        reg_written,
	input  wire logic [4:0]  written_index,
	input  wire logic [31:0] written_value,
	input  wire logic [31:0] next_pc,
	input  wire logic        halted,
	input  wire logic [7:0]  exit_byte,
	input  wire logic        status,
	output int               mismatches,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MEM_BYTES = 1 << MEM_ADDR_BITS_DEF;

	typedef struct packed {
		logic        wr;
		logic [4:0]  idx;
		logic [31:0] val;
		logic [31:0] npc;
		logic        halt;
		logic [7:0]  exit_b;
		logic        bad;
	} retire_t;

	// Shadow architectural state
	logic [31:0] gpr [32];
	logic [31:0] pc_q;
	logic [7:0]  dmem [MEM_BYTES];
	logic        halt_q;
	retire_t     retire_q [$];

	initial begin
		mismatches = 0;
		pending = 0;
	end

	function automatic logic [7:0] mem_rd(input logic [31:0] a);
		return dmem[a[MEM_ADDR_BITS_DEF-1:0]];
	endfunction

	function automatic void mem_wr(input logic [31:0] a, input logic [7:0] v);
		dmem[a[MEM_ADDR_BITS_DEF-1:0]] = v;
	endfunction

	// Execute one instruction against the shadow state
	function automatic retire_t execute_insn(input logic [5:0] op, input logic [4:0] rd,
			input logic [4:0] rs1, input logic [4:0] rs2, input logic [31:0] imm);
		logic [31:0] a, b, pc, npc, val, addr;
		logic [7:0]  m0, m1;
		logic        wr, bad, take;
		retire_t     r;
		a = gpr[rs1];
		b = gpr[rs2];
		pc = pc_q;
		npc = pc + 32'd4;
		val = '0;
		addr = a + imm;
		wr = 1'b0;
		take = 1'b0;
		bad = op > OP_LUI;
		if (!halt_q && op == OP_ADDI && rd == EXIT_REG && rs1 == 5'd0 && imm == EXIT_IMM) begin
			halt_q = 1'b1;
		end else if (!halt_q && !bad) begin
			wr = 1'b1;
			case (op)
				OP_ADD:   val = a + b;
				OP_SUB:   val = a - b;
				OP_AND:   val = a & b;
				OP_OR:    val = a | b;
				OP_XOR:   val = a ^ b;
				OP_SLL:   val = a << b[4:0];
				OP_SRL:   val = a >> b[4:0];
				OP_SRA:   val = $signed(a) >>> b[4:0];
				OP_SLT:   val = {31'd0, $signed(a) < $signed(b)};
				OP_SLTU:  val = {31'd0, a < b};
				OP_SLLI:  val = a << imm[4:0];
				OP_SRLI:  val = a >> imm[4:0];
				OP_SRAI:  val = $signed(a) >>> imm[4:0];
				OP_ADDI:  val = a + imm;
				OP_ANDI:  val = a & imm;
				OP_ORI:   val = a | imm;
				OP_XORI:  val = a ^ imm;
				OP_SLTI:  val = {31'd0, $signed(a) < $signed(imm)};
				OP_SLTIU: val = {31'd0, a < imm};
				OP_LB: begin
					m0 = mem_rd(addr);
					val = {{24{m0[7]}}, m0};
				end
				OP_LBU:   val = {24'd0, mem_rd(addr)};
				OP_LH: begin
					m0 = mem_rd(addr);
					m1 = mem_rd(addr + 32'd1);
					val = {{16{m1[7]}}, m1, m0};
				end
				OP_LHU:   val = {16'd0, mem_rd(addr + 32'd1), mem_rd(addr)};
				OP_LW:    val = {mem_rd(addr + 32'd3), mem_rd(addr + 32'd2),
						mem_rd(addr + 32'd1), mem_rd(addr)};
				OP_JALR: begin
					val = pc + 32'd4;
					npc = addr & ~32'd1;
				end
				OP_JAL: begin
					val = pc + 32'd4;
					npc = pc + imm;
				end
				OP_AUIPC: val = pc + imm;
				OP_LUI:   val = imm;
				default: begin
					wr = 1'b0;
					case (op)
						OP_SB: mem_wr(addr, b[7:0]);
						OP_SH: begin
							mem_wr(addr, b[7:0]);
							mem_wr(addr + 32'd1, b[15:8]);
						end
						OP_SW: begin
							mem_wr(addr, b[7:0]);
							mem_wr(addr + 32'd1, b[15:8]);
							mem_wr(addr + 32'd2, b[23:16]);
							mem_wr(addr + 32'd3, b[31:24]);
						end
						OP_BEQ:  take = a == b;
						OP_BNE:  take = a != b;
						OP_BLT:  take = $signed(a) < $signed(b);
						OP_BGE:  take = !($signed(a) < $signed(b));
						OP_BLTU: take = a < b;
						OP_BGEU: take = a >= b;
						default: ;
					endcase
				end
			endcase
			if (take)
				npc = pc + imm;
			if (wr && rd != 5'd0)
				gpr[rd] = val;
			else
				wr = 1'b0;
			pc_q = npc;
		end
		r.wr = wr;
		r.idx = wr ? rd : 5'd0;
		r.val = wr ? val : 32'd0;
		r.npc = pc_q;
		r.halt = halt_q;
		r.exit_b = halt_q ? gpr[EXIT_REG][7:0] : 8'd0;
		r.bad = bad;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s got %h want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Watch both channels at each edge
	always @(posedge clk) begin
		retire_t e;
		if (!arst_n) begin
			foreach (gpr[i]) gpr[i] = '0;
			foreach (dmem[i]) dmem[i] = '0;
			pc_q = '0;
			halt_q = 1'b0;
			retire_q.delete();
		end else begin
			if (in_valid && !in_stall)
				retire_q.push_back(execute_insn(func, dest_index, src1_index, src2_index,
						immediate));
			if (out_valid && !out_stall) begin
				if (retire_q.size() == 0) begin
					report_mismatch("unexpected result beat, next_pc", next_pc, 32'd0);
				end else begin
					e = retire_q.pop_front();
					if (reg_written !== e.wr)
						report_mismatch("reg_written", 32'(reg_written), 32'(e.wr));
					if (written_index !== e.idx)
						report_mismatch("written_index", 32'(written_index),
								32'(e.idx));
					if (written_value !== e.val)
						report_mismatch("written_value", written_value, e.val);
					if (next_pc !== e.npc)
						report_mismatch("next_pc", next_pc, e.npc);
					if (halted !== e.halt)
						report_mismatch("halted", 32'(halted), 32'(e.halt));
					if (exit_byte !== e.exit_b)
						report_mismatch("exit_byte", 32'(exit_byte), 32'(e.exit_b));
					if (status !== e.bad)
						report_mismatch("status", 32'(status), 32'(e.bad));
				end
			end
		end
		pending = retire_q.size();
	end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Top level: clock, reset, instruction stimulus, result back-pressure and verdict.
`default_nettype none
module testbench
	import rv32x_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_START  = 17500;
	localparam int HOLD_LEN    = 400;
	localparam int NUM_RANDOM  = 1500;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [5:0]  func = OP_ADD;
	logic [4:0]  dest_index = '0;
	logic [4:0]  src1_index = '0;
	logic [4:0]  src2_index = '0;
	logic [31:0] immediate = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        reg_written;
	logic [4:0]  written_index;
	logic [31:0] written_value;
	logic [31:0] next_pc;
	logic        halted;
	logic [7:0]  exit_byte;
	logic        status;
	int          mismatches;
	int          pending;
	int          cycles = 0;
	int          rx_cycles = 0;
	int          rx_hold = 0;
	int          insn_count = 0;

	rv32i_execute_unit dut (.*);

	rv32x_exec_checker checker_i (.*);

	always #6 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Result side back-pressure: random stalls, one long hold, one quiet window
	always @(posedge clk) begin
		int r;
		rx_cycles++;
		if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_LEN) begin
			out_stall <= 1'b1;
		end else if (rx_hold > 0) begin
			rx_hold--;
			out_stall <= 1'b1;
		end else if (rx_cycles >= 30000 && rx_cycles < 32000) begin
			out_stall <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				out_stall <= 1'b0;
			end else if (r < 95) begin
				rx_hold = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				rx_hold = $urandom_range(10, 40);
				out_stall <= 1'b1;
			end
		end
	end

	// Offer one beat and wait until it is taken
	task automatic send_insn(input logic [5:0] op, input logic [4:0] rd,
			input logic [4:0] rs1, input logic [4:0] rs2, input logic [31:0] imm);
		int r;
		func <= op;
		dest_index <= rd;
		src1_index <= rs1;
		src2_index <= rs2;
		immediate <= imm;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		insn_count++;
		// Sender gaps, none in a middle stretch
		r = $urandom_range(0, 99);
		if ((insn_count < 600 || insn_count > 800) && r >= 70) begin
			in_valid <= 1'b0;
			repeat (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40))
				@(posedge clk);
		end
	endtask

	// One random instruction, weighted toward memory traffic near address zero
	task automatic send_random();
		logic [5:0]  op;
		logic [4:0]  rd, rs1, rs2;
		logic [31:0] imm;
		int          cls;
		rd = 5'($urandom);
		rs1 = 5'($urandom);
		rs2 = 5'($urandom);
		imm = $urandom;
		cls = $urandom_range(0, 99);
		if (cls < 25) begin
			op = 6'($urandom_range(OP_ADD, OP_SLTU));
		end else if (cls < 45) begin
			op = 6'($urandom_range(OP_SLLI, OP_SLTIU));
			if ($urandom_range(0, 3) == 0)
				imm = 32'($signed(12'($urandom)));
		end else if (cls < 53) begin
			op = $urandom_range(0, 1) ? OP_LUI : OP_AUIPC;
		end else if (cls < 85) begin
			op = $urandom_range(0, 1) ? 6'($urandom_range(OP_LB, OP_LW))
					: 6'($urandom_range(OP_SB, OP_SW));
			if ($urandom_range(0, 9) < 7) begin
				rs1 = 5'd0;
				imm = $urandom_range(0, 63);
			end
		end else if (cls < 93) begin
			op = 6'($urandom_range(OP_BEQ, OP_BNE));
			if ($urandom_range(0, 1))
				rs2 = rs1;
		end else if (cls < 96) begin
			op = $urandom_range(0, 1) ? OP_JAL : OP_JALR;
		end else begin
			op = $urandom_range(0, 1) ? 6'($urandom_range(OP_EBREAK, OP_ECALL))
					: 6'($urandom_range(OP_LUI + 1, 63));
		end
		// Keep the exit instruction out of the random part
		if (op == OP_ADDI && rd == EXIT_REG && rs1 == 5'd0 && imm == EXIT_IMM)
			imm = 32'd256;
		send_insn(op, rd, rs1, rs2, imm);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: operand extremes, wrapping memory, jumps, invalid codes, x0 writes
		send_insn(OP_LUI,    5'd1,  5'd0, 5'd0, 32'h8000_0000);
		send_insn(OP_ADDI,   5'd2,  5'd0, 5'd0, 32'hFFFF_FFFF);
		send_insn(OP_LUI,    5'd3,  5'd0, 5'd0, 32'h7FFF_FFFF);
		send_insn(OP_SRA,    5'd4,  5'd1, 5'd2, 32'd0);
		send_insn(OP_SRLI,   5'd5,  5'd2, 5'd0, 32'hFFFF_FFFF);
		send_insn(OP_SLT,    5'd6,  5'd1, 5'd3, 32'd0);
		send_insn(OP_SLTU,   5'd7,  5'd1, 5'd3, 32'd0);
		send_insn(OP_SUB,    5'd8,  5'd1, 5'd2, 32'd0);
		send_insn(OP_ADD,    5'd0,  5'd2, 5'd2, 32'd0);
		send_insn(OP_SW,     5'd0,  5'd0, 5'd1, 32'h0000_FFFE);
		send_insn(OP_SH,     5'd0,  5'd0, 5'd2, 32'h0001_0000);
		send_insn(OP_LW,     5'd9,  5'd0, 5'd0, 32'hFFFF_FFFE);
		send_insn(OP_LH,     5'd11, 5'd0, 5'd0, 32'h0000_FFFF);
		send_insn(OP_LHU,    5'd12, 5'd0, 5'd0, 32'h0000_FFFF);
		send_insn(OP_LB,     5'd13, 5'd0, 5'd0, 32'h0000_0000);
		send_insn(OP_LBU,    5'd14, 5'd0, 5'd0, 32'h0000_FFFF);
		send_insn(OP_JALR,   5'd15, 5'd15, 5'd0, 32'h0000_0101);
		send_insn(OP_JAL,    5'd16, 5'd0, 5'd0, 32'hFFFF_FFF0);
		send_insn(OP_BGE,    5'd0,  5'd1, 5'd3, 32'h0000_0040);
		send_insn(OP_BLT,    5'd0,  5'd1, 5'd3, 32'h0000_0040);
		send_insn(OP_AUIPC,  5'd17, 5'd0, 5'd0, 32'h8000_0000);
		send_insn(OP_EBREAK, 5'd0,  5'd0, 5'd0, 32'd0);
		send_insn(OP_ECALL,  5'd0,  5'd0, 5'd0, 32'd0);
		send_insn(6'd63,     5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF);
		send_insn(6'(OP_LUI + 6'd1), 5'd1, 5'd1, 5'd1, 32'd0);

		repeat (NUM_RANDOM)
			send_random();

		// Exit, then items that must be ignored
		send_insn(OP_ADDI, EXIT_REG, 5'd0, 5'd0, EXIT_IMM);
		send_insn(OP_ADD,  5'd1, 5'd2, 5'd3, 32'd0);
		send_insn(6'd50,   5'd1, 5'd2, 5'd3, 32'd0);
		send_insn(OP_SW,   5'd0, 5'd0, 5'd2, 32'd4);
		send_insn(OP_JAL,  5'd5, 5'd0, 5'd0, 32'd64);
		send_insn(OP_ADDI, EXIT_REG, 5'd0, 5'd0, EXIT_IMM);
		in_valid <= 1'b0;
		// let the checker log the last beat before polling its queue
		@(posedge clk);

		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
src/rv32x_pkg.sv
src/rv32x_regfile.sv
src/rv32x_dmem.sv
src/rv32x_exec.sv
src/rv32i_execute_unit.sv
tb/rv32x_exec_checker.sv
tb/testbench.sv
